[sv/ots_pkg.sv]
// ----------------------------------------------------------------------------
// ots_pkg: oscillator trim search shared definitions
// Default widths, register reset values, configuration register indexes and command codes.
// ----------------------------------------------------------------------------
package ots_pkg;

	localparam int TRIM_BITS_DEF  = 7;
	localparam int COUNT_BITS_DEF = 20;

	// reset values of the configuration registers
	localparam int unsigned IDEAL_COUNT_RST = 1808;
	localparam int unsigned START_TRIM_RST  = 64;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_IDEAL_COUNT = 1'b0,
		CFG_START_TRIM  = 1'b1
	} cfg_index_t;

	// command codes of an input request
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_COUNT = 1'b1
	} cmd_code_t;

endpackage

[sv/ots_stream_if.sv]
// ----------------------------------------------------------------------------
// ots stream interfaces
// Valid/ready channels for the command requests and the trim results.
// ----------------------------------------------------------------------------
interface ots_cmd_if #(
	parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [COUNT_BITS-1:0] up_count;

	modport source (output valid, output command, output up_count, input ready);
	modport sink   (input valid, input command, input up_count, output ready);
endinterface

interface ots_rsp_if #(
	parameter int TRIM_BITS = ots_pkg::TRIM_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [TRIM_BITS-1:0] trim_value;
	logic                 done_res;
	logic                 run_again;

	modport source (output valid, output trim_value, output done_res, output run_again,
		input ready);
	modport sink   (input valid, input trim_value, input done_res, input run_again,
		output ready);
endinterface

[sv/oscillator_trim_search_core.sv]
// ----------------------------------------------------------------------------
// oscillator_trim_search_core
// Step-by-step RC oscillator trim search: start requests load the start trim,
// count requests nudge the trim toward the ideal count until it is reached, within one, or crossed.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  cmd      | in  | valid/ready  | command, up_count
//  rsp      | out | valid/ready  | trim_value, done_res, run_again
//  cfg      | in  | cfg_we       | cfg_index, cfg_data (no read-back)
//
//  one request per cycle while results are taken; a result becomes valid after the request passes
//  the input register (accepting edge) and then compare/update into the result register
//  the search state is updated as a request leaves the input register
//  arst_n clears the valids and the search state (search idle, done set)
//  a stalled result holds; the input register takes one more request, then ready drops
// ----------------------------------------------------------------------------
module oscillator_trim_search_core #(
	parameter int TRIM_BITS  = ots_pkg::TRIM_BITS_DEF,
	parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF,
	localparam int CFG_BITS  = (COUNT_BITS > TRIM_BITS) ? COUNT_BITS : TRIM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ots_cmd_if.sink                           cmd,
	ots_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [ots_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]               cfg_data
);

	// configuration registers
	logic [COUNT_BITS-1:0] ideal_count_q;
	logic [TRIM_BITS-1:0]  start_trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_count_q <= COUNT_BITS'(ots_pkg::IDEAL_COUNT_RST);
			start_trim_q  <= TRIM_BITS'(ots_pkg::START_TRIM_RST);
		end else if (cfg_we) begin
			case (ots_pkg::cfg_index_t'(cfg_index))
				ots_pkg::CFG_IDEAL_COUNT: ideal_count_q <= cfg_data[COUNT_BITS-1:0];
				ots_pkg::CFG_START_TRIM:  start_trim_q  <= cfg_data[TRIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                  valid_s1;
	logic                  command_s1;
	logic [COUNT_BITS-1:0] up_count_s1;
	logic                  adv_s1;
	logic                  valid_s2;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			command_s1  <= cmd.command;
			up_count_s1 <= cmd.up_count;
		end
	end

	// search state
	logic [TRIM_BITS-1:0]  trim_now_q;
	logic [TRIM_BITS-1:0]  trim_before_q;
	logic [COUNT_BITS-1:0] count_before_q;
	logic                  was_below_q;
	logic                  was_above_q;
	logic                  finished_q;

	// compare and next-state logic
	logic                  below;
	logic                  above;
	logic [COUNT_BITS-1:0] dist_cur;
	logic [COUNT_BITS-1:0] dist_prev;
	logic                  keep_prev;
	logic [TRIM_BITS-1:0]  trim_nx;
	logic [TRIM_BITS-1:0]  trim_before_nx;
	logic [COUNT_BITS-1:0] count_before_nx;
	logic                  was_below_nx;
	logic                  was_above_nx;
	logic                  finished_nx;

	assign below     = up_count_s1 < ideal_count_q;
	assign above     = up_count_s1 > ideal_count_q;
	assign dist_cur  = below ? (ideal_count_q - up_count_s1) : (up_count_s1 - ideal_count_q);
	assign dist_prev = (count_before_q > ideal_count_q) ? (count_before_q - ideal_count_q)
		: (ideal_count_q - count_before_q);
	// on a crossing, fall back to the earlier trim only if it was strictly closer
	assign keep_prev = dist_cur > dist_prev;

	always_comb begin
		trim_nx         = trim_now_q;
		trim_before_nx  = trim_before_q;
		count_before_nx = count_before_q;
		was_below_nx    = was_below_q;
		was_above_nx    = was_above_q;
		finished_nx     = finished_q;
		if (ots_pkg::cmd_code_t'(command_s1) == ots_pkg::CMD_START) begin
			finished_nx  = 1'b0;
			was_below_nx = 1'b0;
			was_above_nx = 1'b0;
			trim_nx      = start_trim_q;
		end else if (!finished_q) begin
			if (below) begin
				if (was_above_q) begin
					if (keep_prev) trim_nx = trim_before_q;
					finished_nx = 1'b1;
				end else if (dist_cur == COUNT_BITS'(1)) begin
					finished_nx = 1'b1;
				end else begin
					trim_before_nx  = trim_now_q;
					if (trim_now_q != '1) trim_nx = trim_now_q + TRIM_BITS'(1);
					was_below_nx    = 1'b1;
					count_before_nx = up_count_s1;
				end
			end else if (above) begin
				if (was_below_q) begin
					if (keep_prev) trim_nx = trim_before_q;
					finished_nx = 1'b1;
				end else if (dist_cur == COUNT_BITS'(1)) begin
					finished_nx = 1'b1;
				end else begin
					trim_before_nx  = trim_now_q;
					if (trim_now_q != '0) trim_nx = trim_now_q - TRIM_BITS'(1);
					was_above_nx    = 1'b1;
					count_before_nx = up_count_s1;
				end
			end else begin
				finished_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_now_q     <= '0;
			trim_before_q  <= '0;
			count_before_q <= '0;
			was_below_q    <= 1'b0;
			was_above_q    <= 1'b0;
			finished_q     <= 1'b1;
		end else if (adv_s1) begin
			trim_now_q     <= trim_nx;
			trim_before_q  <= trim_before_nx;
			count_before_q <= count_before_nx;
			was_below_q    <= was_below_nx;
			was_above_q    <= was_above_nx;
			finished_q     <= finished_nx;
		end
	end

	// result register
	logic [TRIM_BITS-1:0] trim_s2;
	logic                 done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			trim_s2 <= trim_nx;
			done_s2 <= finished_nx;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.trim_value = trim_s2;
	assign rsp.done_res   = done_s2;
	assign rsp.run_again  = !done_s2;

	// the held result always mirrors the search state it left behind
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (trim_s2 == trim_now_q) && (done_s2 == finished_q))
		else $error("result register out of step with search state");

	// a search never records both directions
	a_crossing_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(was_below_q && was_above_q))
		else $error("both crossing flags set");

	// a start request opens a fresh search
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && command_s1 == ots_pkg::CMD_START) |=>
		(!finished_q && !was_below_q && !was_above_q && trim_now_q == $past(start_trim_q)))
		else $error("start request did not reset the search");

	// counts after the search has finished change nothing
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && command_s1 == ots_pkg::CMD_COUNT && finished_q) |=>
		(finished_q && $stable(trim_now_q)))
		else $error("count request altered a finished search");

endmodule
